@@ design/cprb_pkg.sv @@
// ----------------------------------------------------------------------------
// Column planes to row bitmap: shared package
// Register codes, size defaults, lane geometry and the read descriptor that
// travels from the issue stage to the merge stage.
// ----------------------------------------------------------------------------
`default_nettype none

package cprb_pkg;

  // Default picture limits.
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Configuration port geometry and register codes.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  // Reset value of both size registers.
  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 11'd1024;

  // One lane per row of a band; each lane word holds 32 pixels of a row.
  localparam int LANES     = 8;
  localparam int LANE_W    = 3;
  localparam int WORD_BITS = 32;
  localparam int CNT_W     = 6;

  // Status codes of a read result.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Read descriptor held while the lane memories fetch the row word.
  typedef struct packed {
    logic              status;
    logic [LANE_W-1:0] lane;
    logic [CNT_W-1:0]  keep_cnt;  // pixels of this word inside the picture
    logic [CNT_W-1:0]  pad_cnt;   // pixels up to the end of the last data byte
  } rd_meta_t;

endpackage

`default_nettype wire

@@ design/cprb_if.sv @@
// ----------------------------------------------------------------------------
// Column planes to row bitmap: channel interfaces
// Command channel and result channel, each a valid/ready beat with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface cprb_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [9:0] src_column;
  logic [6:0] band;
  logic [7:0] plane_one_byte;
  logic [7:0] plane_two_byte;
  logic [9:0] out_row;
  logic [4:0] out_word;

  modport source (
    output valid, cmd, src_column, band, plane_one_byte, plane_two_byte, out_row, out_word,
    input  ready
  );
  modport sink (
    input  valid, cmd, src_column, band, plane_one_byte, plane_two_byte, out_row, out_word,
    output ready
  );
endinterface

interface cprb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_word;
  logic        status;

  modport source (output valid, pixel_word, status, input ready);
  modport sink   (input valid, pixel_word, status, output ready);
endinterface

`default_nettype wire

@@ design/column_planes_to_row_bitmap.sv @@
// A read beat gives its result via the read descriptor stage and the output
// register; a load beat writes up to eight pixels when accepted, with no result.
// Throughput: one beat per cycle while results are taken, loads and reads mixed
// in any order; a read fetches a word from each of the eight row lanes at once.
// Reset clears the pipeline valid flags and sets both picture sizes to 1024.
// The pixel store is not cleared; a pixel reads back only after it was loaded.
// ----------------------------------------------------------------------------
// Column planes to row bitmap: top level
// Converts column bytes from two bit planes into a top-down 1-bit bitmap that
// is read one 32-bit row word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module column_planes_to_row_bitmap
  import cprb_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  cprb_in_if.sink                    in_ch,
  cprb_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int WORDS  = (MAX_WIDTH + WORD_BITS - 1) / WORD_BITS;
  localparam int ROWS   = (MAX_HEIGHT + LANES - 1) / LANES;
  localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BAND_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW     = BAND_W + WORD_W;
  localparam logic [11:0] MAXW_C = 12'(MAX_WIDTH);
  localparam logic [11:0] MAXH_C = 12'(MAX_HEIGHT);

  // Configuration registers.
  logic [CFG_DATA_W-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_RESET;
      height_r <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake and pipeline control.
  logic     s1_valid_r, s1_valid_nxt;
  rd_meta_t s1_meta_r, s1_meta_nxt;
  logic     out_valid_r;
  logic [WORD_BITS-1:0] out_word_r;
  logic     out_status_r;
  logic     out_free, in_ready, accept, rd_acc, ld_acc;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = !s1_valid_r || out_free;
  assign accept   = in_ch.valid && in_ready;
  assign rd_acc   = accept && in_ch.cmd;
  assign ld_acc   = accept && !in_ch.cmd;
  assign in_ch.ready = in_ready;

  logic size_ok;
  assign size_ok = (width_r != '0) && ({1'b0, width_r} <= MAXW_C) &&
                   (height_r != '0) && ({1'b0, height_r} <= MAXH_C);

  // Load decode: target column and word position inside each lane.
  logic            col_ok;
  logic [10:0]     load_x;
  logic [7:0]      any_bits;
  logic [AW-1:0]   wr_addr;

  assign col_ok   = {1'b0, in_ch.src_column} < width_r;
  assign load_x   = width_r - 11'd1 - {1'b0, in_ch.src_column};
  assign any_bits = in_ch.plane_one_byte | in_ch.plane_two_byte;
  assign wr_addr  = {BAND_W'(in_ch.band), WORD_W'(load_x[10:5])};

  // Read decode: range check and the pixel counts of the requested word.
  logic [11:0]      rem;
  logic [CNT_W-1:0] keep;
  logic [6:0]       pad_sum;
  logic             rd_err;
  logic [AW-1:0]    rd_addr;

  assign rem     = {1'b0, width_r} - {2'b00, in_ch.out_word, 5'b00000};
  assign keep    = (rem > 12'd32) ? 6'd32 : rem[5:0];
  assign pad_sum = {1'b0, keep} + 7'd7;
  assign rd_err  = !size_ok || ({1'b0, in_ch.out_row} >= height_r) ||
                   ({1'b0, in_ch.out_word, 5'b00000} >= width_r);
  assign rd_addr = {BAND_W'(in_ch.out_row[9:3]), WORD_W'(in_ch.out_word)};

  always_comb begin
    s1_meta_nxt.status   = rd_err ? STATUS_ERR : STATUS_OK;
    s1_meta_nxt.lane     = in_ch.out_row[LANE_W-1:0];
    s1_meta_nxt.keep_cnt = keep;
    s1_meta_nxt.pad_cnt  = CNT_W'({pad_sum[6:3], 3'b000});
    s1_valid_nxt         = rd_acc;
  end

  // Row lanes: lane k holds rows whose low three bits equal k.
  logic [LANES-1:0][WORD_BITS-1:0] lane_data;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic lane_we;
    assign lane_we = ld_acc && size_ok && col_ok &&
                     ({1'b0, in_ch.band, LANE_W'(k)} < height_r);

    cprb_lane #(
      .BAND_W (BAND_W),
      .WORD_W (WORD_W)
    ) u_lane (
      .clk     (clk),
      .wr_en   (lane_we),
      .wr_addr (wr_addr),
      .wr_bit  (load_x[4:0]),
      .wr_val  (~any_bits[LANES-1-k]),
      .rd_en   (rd_acc),
      .rd_addr (rd_addr),
      .rd_data (lane_data[k])
    );
  end

  // Merge of the lane words into the file word.
  logic [WORD_BITS-1:0] merged_word;
  logic                 merged_status;

  cprb_merge u_merge (
    .lane_data  (lane_data),
    .meta       (s1_meta_r),
    .pixel_word (merged_word),
    .status     (merged_status)
  );

  // Read descriptor stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_meta_r <= s1_meta_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_word_r   <= merged_word;
      out_status_r <= merged_status;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_word = out_word_r;
  assign out_ch.status     = out_status_r;

endmodule

`default_nettype wire

@@ design/cprb_lane.sv @@
// ----------------------------------------------------------------------------
// Column planes to row bitmap: row lane
// Stores every eighth pixel row as 32-pixel words. A load sets one pixel
// through a bit write; a read returns a whole word in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cprb_lane
  import cprb_pkg::*;
#(
  parameter int BAND_W = 7,
  parameter int WORD_W = 5
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [BAND_W+WORD_W-1:0]   wr_addr,
  input  wire logic [4:0]                 wr_bit,
  input  wire logic                       wr_val,
  input  wire logic                       rd_en,
  input  wire logic [BAND_W+WORD_W-1:0]   rd_addr,
  output logic      [WORD_BITS-1:0]       rd_data
);

  localparam int DEPTH = 1 << (BAND_W + WORD_W);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;

  // Single pixel write into the addressed word.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr][wr_bit] <= wr_val;
    end
  end

  // Registered word read; holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ design/cprb_merge.sv @@
// ----------------------------------------------------------------------------
// Column planes to row bitmap: lane merge
// Picks the lane of the requested row and forms the file word: stored pixels
// inside the picture, white padding to the end of the last data byte, zero
// bytes after it, and an all-zero word for a rejected request.
// ----------------------------------------------------------------------------
`default_nettype none

module cprb_merge
  import cprb_pkg::*;
(
  input  wire logic [LANES-1:0][WORD_BITS-1:0] lane_data,
  input  wire rd_meta_t                        meta,
  output logic      [WORD_BITS-1:0]            pixel_word,
  output logic                                 status
);

  logic [WORD_BITS-1:0] sel_word;

  // Lane select by the low row bits.
  assign sel_word = lane_data[meta.lane];

  // Pixel j of the word sits at memory bit j and at file bit 31-j.
  always_comb begin
    pixel_word = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (CNT_W'(j) < meta.keep_cnt) begin
        pixel_word[WORD_BITS-1-j] = sel_word[j];
      end else if (CNT_W'(j) < meta.pad_cnt) begin
        pixel_word[WORD_BITS-1-j] = 1'b1;
      end else begin
        pixel_word[WORD_BITS-1-j] = 1'b0;
      end
    end
    if (meta.status == STATUS_ERR) begin
      pixel_word = '0;
    end
  end

  assign status = meta.status;

endmodule

`default_nettype wire
